FILE: rtl/stg_pkg.sv
// Shared types, constants and the sine table builder for the sine tone generator.
// No dependencies; every other file imports this package.

package stg_pkg;

  // field and register widths
  localparam int FREQ_W     = 21;
  localparam int AMP_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 18;
  localparam int CNT_W      = 18;
  localparam int DIVR_W     = 22;   // 16*rate and divisor width
  localparam int MAG_W      = 15;   // table magnitude
  localparam int PROD_W     = MAG_W + AMP_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // reset values (440 Hz tone at 44.1 kHz)
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 21'd7040;
  localparam logic [CNT_W-1:0]  PERIOD_MAX = 18'h3FFFF;

  // register word index
  localparam logic REG_SAMPLE_RATE = 1'b0;

  // 2*pi in Q30
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned MAG_MAX    = 64'd32767;

  typedef enum logic [2:0] {
    ST_PER_GO,
    ST_PER_RUN,
    ST_INC_GO,
    ST_INC_RUN,
    ST_ZERO,
    ST_IDLE,
    ST_MUL,
    ST_OUT
  } stg_state_t;

  // controller to datapath
  typedef struct packed {
    logic div_per;     // start period division
    logic div_inc;     // start increment division
    logic load_per;    // take period from quotient
    logic load_inc;    // take increment from quotient
    logic tick_end;    // period end beat: new frequency, counter to 1
    logic tick_step;   // ordinary beat: table read, phase and counter step
    logic phase_sync;  // phase takes the new increment
    logic mul;         // magnitude times amplitude
    logic out_sample;  // load rounded sample into output register
    logic out_zero;    // load zero into output register
  } stg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic period_end;
    logic out_free;
  } stg_sts_t;

  // unsigned shift-and-subtract quotient, elaboration only
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767*sin(2*pi*q/2^tb)) for 0 <= q <= 2^(tb-2), Q30 Taylor series.
  // Evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q,
                                                    input int unsigned tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dvsr;
    longint unsigned mag;
    longint          sum;
    x    = (TWO_PI_Q30 * 64'(q)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      dvsr = 64'((2 * k) * (2 * k + 1));
      term = div_u64((term * x2) >> 30, dvsr);
      if (k[0])
        sum = sum - longint'(term);
      else
        sum = sum + longint'(term);
    end
    if (sum < 0)
      sum = 0;
    mag = (64'(sum) * MAG_MAX + (64'd1 << 29)) >> 30;
    if (mag > MAG_MAX)
      mag = MAG_MAX;
    return MAG_W'(mag);
  endfunction

endpackage

FILE: rtl/sine_tone_generator_core.sv
// Sine tone generator, top level: stream ports, register port, controller and datapath.
// Ordinary beat: table read, multiply, then the rounded sample goes into the output register;
// the next beat is taken only once that register has been loaded. Period-end beat: the
// period division (22 steps) and the increment division (PHASE_BITS + 21 steps) run, then a
// zero result is loaded. Reset is synchronous; in_tready stays low after reset release and
// after each sample_rate write while period and increment are recomputed.

module sine_tone_generator_core import stg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [20:0] target_frequency, [36:21] amplitude
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] sample
  // register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  stg_cmd_t          cmd;
  stg_sts_t          sts;
  logic              cfg_wr;
  logic              cfg_hit;
  logic [RATE_W-1:0] rate;

  // register decode
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_ADDR_W-1] == REG_SAMPLE_RATE;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(rate) : '0;

  stg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  stg_dp #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr           (cfg_wr),
    .cfg_rate         (cfg_pwdata[RATE_W-1:0]),
    .rate             (rate),
    .target_frequency (in_tdata[FREQ_W-1:0]),
    .amplitude        (in_tdata[FREQ_W+AMP_W-1:FREQ_W]),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .sample           (out_tdata)
  );

endmodule

FILE: rtl/stg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on stg_pkg for the divisor width.

module stg_div import stg_pkg::*; #(
  parameter int DVD_W = 53
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [DVD_W-1:0]                 dividend,
  input  logic [DIVR_W-1:0]                divisor,
  input  logic [$clog2(DVD_W+1)-1:0]       nbits,
  output logic                             busy,
  output logic [DVD_W-1:0]                 quot
);

  localparam int CB = $clog2(DVD_W + 1);

  logic [CB-1:0]     cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVD_W-1:0]  quot_r, quot_nxt;
  logic [DIVR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_diff;
  logic              ge;

  // one restoring step
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = nbits;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      quot_nxt = '0;
      rem_nxt  = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      dvd_nxt  = dvd_r << 1;
      quot_nxt = {quot_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      cnt_r <= '0;
    else
      cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = cnt_r != '0;
  assign quot = quot_r;

endmodule

FILE: rtl/stg_dp.sv
// Datapath: oscillator state, sine table, amplitude scaling, output register.
// Depends on stg_pkg and stg_div.

module stg_dp import stg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stg_cmd_t            cmd,
  output stg_sts_t            sts,
  input  logic                cfg_wr,
  input  logic [RATE_W-1:0]   cfg_rate,
  output logic [RATE_W-1:0]   rate,
  input  logic [FREQ_W-1:0]   target_frequency,
  input  logic [AMP_W-1:0]    amplitude,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] sample
);

  localparam int DVD_W   = FREQ_W + PHASE_BITS;
  localparam int CB      = $clog2(DVD_W + 1);
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int QI_W    = TABLE_BITS - 1;

  logic [RATE_W-1:0]     rate_r, rate_nxt;
  logic [FREQ_W-1:0]     freq_r, freq_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      period_r, period_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] inc_r, inc_nxt;
  logic [AMP_W-1:0]      amp_r;
  logic [MAG_W-1:0]      mag_r;
  logic                  neg_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_sample_r;

  // sine table, quarter wave
  logic [MAG_W-1:0] qrom [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qrom
    localparam logic [MAG_W-1:0] QV = quarter_sine(g, TABLE_BITS);
    assign qrom[g] = QV;
  end

  // division operands
  logic [RATE_W-1:0] rate_eff;
  logic [FREQ_W-1:0] freq_eff;
  logic [DIVR_W-1:0] den;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DIVR_W-1:0] div_dsr;
  logic [CB-1:0]     div_nbits;
  logic              div_busy;
  logic [DVD_W-1:0]  div_quot;

  assign rate_eff  = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign freq_eff  = (freq_r == '0) ? FREQ_W'(1) : freq_r;
  assign den       = {rate_eff, 4'b0000};
  assign div_start = cmd.div_per | cmd.div_inc;
  assign div_dvd   = cmd.div_per ? {den, {(DVD_W-DIVR_W){1'b0}}}
                                 : {freq_eff, {PHASE_BITS{1'b0}}};
  assign div_dsr   = cmd.div_per ? DIVR_W'(freq_eff) : den;
  assign div_nbits = cmd.div_per ? CB'(DIVR_W) : CB'(DVD_W);

  stg_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .nbits    (div_nbits),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // period clamp to [1, PERIOD_MAX]
  logic [DIVR_W-1:0] per_q;
  logic [CNT_W-1:0]  per_val;

  assign per_q   = div_quot[DIVR_W-1:0];
  assign per_val = (per_q == '0) ? CNT_W'(1) :
                   (per_q > DIVR_W'(PERIOD_MAX)) ? PERIOD_MAX : per_q[CNT_W-1:0];

  // table address with quarter-wave folding
  logic [TABLE_BITS-1:0] tidx;
  logic [TABLE_BITS-3:0] tofs;
  logic [QI_W-1:0]       qidx;

  assign tidx = phase_r[PHASE_BITS-1 -: TABLE_BITS];
  assign tofs = tidx[TABLE_BITS-3:0];
  assign qidx = tidx[TABLE_BITS-2] ? (QI_W'(QUARTER) - {1'b0, tofs}) : {1'b0, tofs};

  // rounding of the scaled magnitude
  logic [PROD_W-1:0]   rnd;
  logic [MAG_W-1:0]    mag_out;
  logic [SAMPLE_W-1:0] smp_val;

  assign rnd     = prod_r + PROD_W'(32768);
  assign mag_out = rnd[PROD_W-1:AMP_W];
  assign smp_val = neg_r ? (SAMPLE_W'(0) - {1'b0, mag_out}) : {1'b0, mag_out};

  // oscillator state update
  always_comb begin
    rate_nxt   = rate_r;
    freq_nxt   = freq_r;
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    phase_nxt  = phase_r;
    inc_nxt    = inc_r;
    if (cmd.load_per)
      period_nxt = per_val;
    if (cmd.load_inc)
      inc_nxt = div_quot[PHASE_BITS-1:0];
    if (cmd.phase_sync)
      phase_nxt = inc_r;
    if (cmd.tick_end) begin
      freq_nxt = target_frequency;
      cnt_nxt  = CNT_W'(1);
    end
    if (cmd.tick_step) begin
      cnt_nxt   = cnt_r + 1'b1;
      phase_nxt = phase_r + inc_r;
    end
    if (cfg_wr) begin
      rate_nxt  = cfg_rate;
      cnt_nxt   = '0;
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RESET;
      freq_r   <= FREQ_RESET;
      cnt_r    <= '0;
      period_r <= CNT_W'(1);
      phase_r  <= '0;
      inc_r    <= '0;
    end else begin
      rate_r   <= rate_nxt;
      freq_r   <= freq_nxt;
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
      phase_r  <= phase_nxt;
      inc_r    <= inc_nxt;
    end
  end

  // table read, then multiply
  always_ff @(posedge clk) begin
    if (cmd.tick_step) begin
      amp_r <= amplitude;
      mag_r <= qrom[qidx];
      neg_r <= tidx[TABLE_BITS-1];
    end
    if (cmd.mul)
      prod_r <= PROD_W'(mag_r) * PROD_W'(amp_r);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_sample || cmd.out_zero)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sample)
      out_sample_r <= smp_val;
    else if (cmd.out_zero)
      out_sample_r <= '0;
  end

  assign sts.div_busy   = div_busy;
  assign sts.period_end = ({1'b0, cnt_r} + 1'b1) >= {1'b0, period_r};
  assign sts.out_free   = !out_valid_r || out_ready;

  assign rate      = rate_r;
  assign out_valid = out_valid_r;
  assign sample    = out_sample_r;

endmodule

FILE: rtl/stg_ctrl.sv
// Controller state machine: sequences beats, divisions and output loads.
// Depends on stg_pkg for the state, command and status types.

module stg_ctrl import stg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     cfg_wr,
  input  stg_sts_t sts,
  output logic     in_ready,
  output stg_cmd_t cmd
);

  stg_state_t state_r, state_nxt;
  logic       tick_r, tick_nxt;
  logic       accept;

  assign accept = (state_r == ST_IDLE) && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_PER_GO:  state_nxt = ST_PER_RUN;
      ST_PER_RUN: if (!sts.div_busy) state_nxt = ST_INC_GO;
      ST_INC_GO:  state_nxt = ST_INC_RUN;
      ST_INC_RUN: begin
        if (!sts.div_busy)
          state_nxt = tick_r ? ST_ZERO : ST_IDLE;
      end
      ST_ZERO:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid)
          state_nxt = sts.period_end ? ST_PER_GO : ST_MUL;
      end
      ST_MUL:     state_nxt = ST_OUT;
      ST_OUT:     if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
    // register write restarts the recompute
    if (cfg_wr)
      state_nxt = ST_PER_GO;
  end

  // period end beat remembered across the divisions
  always_comb begin
    tick_nxt = tick_r;
    if (accept)
      tick_nxt = sts.period_end;
    if (cfg_wr)
      tick_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PER_GO;
      tick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_PER_GO:  cmd.div_per  = 1'b1;
      ST_PER_RUN: cmd.load_per = !sts.div_busy;
      ST_INC_GO:  cmd.div_inc  = 1'b1;
      ST_INC_RUN: cmd.load_inc = !sts.div_busy;
      ST_ZERO: begin
        cmd.phase_sync = 1'b1;
        cmd.out_zero   = sts.out_free;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.tick_end  = in_valid && sts.period_end;
        cmd.tick_step = in_valid && !sts.period_end;
      end
      ST_MUL:     cmd.mul        = 1'b1;
      ST_OUT:     cmd.out_sample = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

FILE: rtl/stg_checker.sv
// Port-level checks for the sine tone generator, bound to the top level.
// Depends on stg_pkg for port widths.

module stg_checker import stg_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_psel,
  input logic                   cfg_penable,
  input logic                   cfg_pwrite,
  input logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input logic                   cfg_pready
);

  // nothing offered or taken straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("stg: ports active after reset");

  // one beat at a time: acceptance drops ready
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("stg: second beat taken back to back");

  // sample_rate write starts a recompute
  a_cfg_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
    (cfg_paddr[CFG_ADDR_W-1] == REG_SAMPLE_RATE) |=> !in_tready)
    else $error("stg: ready during recompute");

  // scaled magnitude never reaches full negative scale
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 16'h8000)
    else $error("stg: sample out of range");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stg: stalled result changed");

endmodule

bind sine_tone_generator_core stg_checker u_stg_checker (.*);

FILE: tb/sv/tb_sine_tone_generator_core.sv
// Self-checking testbench for sine_tone_generator_core: directed and random audio ticks,
// several sample rates, random idling and one long receiver stall.
// Depends on stg_pkg and the core RTL only.

module tb_sine_tone_generator_core;
  import stg_pkg::*;

  localparam int PH_BITS       = 32;
  localparam int TAB_BITS      = 10;
  localparam int TAB_SIZE      = 1 << TAB_BITS;
  localparam int QUART         = TAB_SIZE / 4;
  localparam int STALL_LIMIT   = 5000;   // cycles without any beat
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 100;    // covers the recompute
  localparam logic [FREQ_W-1:0] FREQ_ALL = '1;

  // Scoreboard: own oscillator state, sine table and queue of samples due
  class tone_scoreboard;
    logic signed [SAMPLE_W-1:0] sine_rom [TAB_SIZE];
    logic [RATE_W-1:0]   rate;
    logic [FREQ_W-1:0]   freq_now;
    logic [CNT_W-1:0]    frame_no;
    logic [CNT_W-1:0]    period;
    logic [PH_BITS-1:0]  phase;
    logic [PH_BITS-1:0]  phase_step;
    logic [SAMPLE_W-1:0] samples_due [$];
    int                  errors;

    function new();
      int quad;
      int r;
      int mag;
      for (int i = 0; i < TAB_SIZE; i++) begin
        quad = i / QUART;
        r    = i % QUART;
        mag  = (quad % 2 == 1) ? quarter_mag(QUART - r) : quarter_mag(r);
        sine_rom[i] = SAMPLE_W'((quad >= 2) ? -mag : mag);
      end
      errors   = 0;
      rate     = RATE_RESET;
      freq_now = FREQ_RESET;
      frame_no = '0;
      phase    = '0;
      retune();
    endfunction

    // 32767*sin over the first quarter, Q30 Taylor series truncated per term
    function int quarter_mag(int unsigned q);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned den;
      longint unsigned mag;
      longint          acc;
      ang    = (TWO_PI_Q30 * 64'(q)) >> TAB_BITS;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int k = 1; k <= 6; k++) begin
        den  = 64'((2 * k) * (2 * k + 1));
        term = ((term * ang_sq) >> 30) / den;
        if (k % 2 == 1)
          acc = acc - longint'(term);
        else
          acc = acc + longint'(term);
      end
      if (acc < 0)
        acc = 0;
      mag = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767)
        mag = 64'd32767;
      return int'(mag);
    endfunction

    // period and phase step from the current frequency and rate
    function void retune();
      longint unsigned f;
      longint unsigned d;
      longint unsigned p;
      f = (freq_now == 0) ? 64'd1 : 64'(freq_now);
      d = ((rate == 0) ? 64'd1 : 64'(rate)) * 64'd16;
      phase_step = PH_BITS'((f << PH_BITS) / d);
      p = d / f;
      if (p < 1)
        p = 1;
      if (p > 64'(PERIOD_MAX))
        p = 64'(PERIOD_MAX);
      period = CNT_W'(p);
    endfunction

    function void set_rate(logic [RATE_W-1:0] v);
      rate     = v;
      frame_no = '0;
      phase    = '0;
      retune();
    endfunction

    function bit at_period_end();
      return 32'(frame_no) + 1 >= 32'(period);
    endfunction

    // accepted tick: work out the sample it causes
    function void note_tick(logic [FREQ_W-1:0] f, logic [AMP_W-1:0] a);
      int     sv;
      longint mag_v;
      if (at_period_end()) begin
        freq_now = f;
        retune();
        frame_no = 1;
        phase    = phase_step;
        samples_due.push_back('0);
      end else begin
        sv    = sine_rom[phase[PH_BITS-1 -: TAB_BITS]];
        mag_v = (longint'((sv < 0) ? -sv : sv) * longint'(a) + 32768) >> 16;
        samples_due.push_back(SAMPLE_W'((sv < 0) ? -mag_v : mag_v));
        phase    = phase + phase_step;
        frame_no = frame_no + 1;
      end
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (samples_due.size() == 0) begin
        $display("%0t: sample %0d arrived with none expected", $time, $signed(got));
        errors++;
      end else begin
        want = samples_due.pop_front();
        if (got !== want) begin
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [20:0] target_frequency, [36:21] amplitude
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] sample
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  tone_scoreboard sb;
  bit steady;     // no idling on either side
  bit hold_ask;   // ask the receiver for a long stall
  int hold_left;
  int idle_run;

  // amplitude sweep for the directed part, every bit toggles
  logic [AMP_W-1:0] amp_sweep [16] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                                       16'hFFFF, 16'h7FFF, 16'h0002, 16'hFFFF,
                                       16'hBFFF, 16'h4000, 16'hFFFF, 16'h1234,
                                       16'hFFFE, 16'h0001, 16'h9C40, 16'hFFFF};

  sine_tone_generator_core #(
    .PHASE_BITS (PH_BITS),
    .TABLE_BITS (TAB_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one input beat, with an occasional idle gap in front
  task automatic send_tick(input logic [FREQ_W-1:0] f, input logic [AMP_W-1:0] a);
    if (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({a, f});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(f, a);
  endtask

  // target that keeps periods at or below about 60 ticks at the current rate
  function automatic logic [FREQ_W-1:0] pick_target();
    longint unsigned d;
    longint unsigned lo;
    longint unsigned hi;
    d  = ((sb.rate == 0) ? 64'd1 : 64'(sb.rate)) * 64'd16;
    lo = d / 60;
    hi = ($urandom_range(9) < 7) ? 64'(FREQ_ALL) : lo * 8 + 8;
    if (hi > 64'(FREQ_ALL))
      hi = 64'(FREQ_ALL);
    return FREQ_W'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++)
      send_tick(pick_target(), AMP_W'($urandom));
  endtask

  // run to the next period end so that f is the frequency in force
  task automatic steer_to(input logic [FREQ_W-1:0] f);
    while (!sb.at_period_end())
      send_tick(f, AMP_W'($urandom));
    send_tick(f, AMP_W'($urandom));
  endtask

  // one register transfer: setup then access; the bus is left selected
  task automatic reg_access(input bit wr, input logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_ADDR_W'(REG_SAMPLE_RATE) << 2;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (wr) begin
      sb.set_rate(RATE_W'(v));
    end else if (cfg_prdata !== CFG_DATA_W'(sb.rate)) begin
      $display("%0t: sample_rate readback mismatch, expected %0d, got %0d",
               $time, sb.rate, cfg_prdata);
      sb.errors++;
    end
  endtask

  // stop offering, let every sample due come out, then a quiet pause
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic change_rate(input logic [RATE_W-1:0] v);
    drain();
    reg_access(1'b1, CFG_DATA_W'(v));
    reg_access(1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // result side: check beats, random back-pressure and the long stall
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_sample(out_tdata);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  // watchdog: too long without any beat on either stream
  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Verification failed");
    $finish;
  end

  // main sequence
  initial begin
    sb = new();
    steady   = 1'b0;
    hold_ask = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset, then check the reset value of the register
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_access(1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;

    // default 440 Hz at 44.1 kHz, then random tones
    run_ticks(120);
    steer_to(21'd6400);

    // lowest nominal rate
    change_rate(18'd8000);
    run_ticks(150);
    steer_to(21'd153600);

    // highest nominal rate, with a long receiver stall part way
    change_rate(18'd192000);
    run_ticks(30);
    hold_ask = 1'b1;
    run_ticks(120);
    // 1/16 Hz here saturates the period length
    steer_to(21'd1);
    run_ticks(5);

    // zero rate: directed amplitude sweep, increment overflow, zero frequency
    change_rate(18'd0);
    for (int i = 0; i < 16; i++)
      send_tick(FREQ_ALL, amp_sweep[i]);
    send_tick(21'd1536000, 16'hFFFF);
    send_tick(21'd0, 16'hFFFF);
    send_tick(21'h0AAAAA, 16'hFFFF);
    send_tick(21'h155555, 16'h5555);
    run_ticks(60);
    steer_to(21'd209714);

    // all-ones rate
    change_rate(18'h3FFFF);
    run_ticks(150);
    steer_to(21'd38400);

    // 48 kHz with a stretch of no idling on either side
    change_rate(18'd48000);
    run_ticks(60);
    steady = 1'b1;
    run_ticks(100);
    steady = 1'b0;
    run_ticks(60);

    drain();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
